FILE: design/spe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants of the shortest path engine
// Fixed field widths, item mode codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int VERTEX_W = 6;
	localparam int DIST_W = 22;
	localparam int WEIGHT_IN_W = 16;
	localparam logic [DIST_W-1:0] DIST_MAX = 22'd4194303;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_SCAN   = 9'b000000100,
		ST_PICK   = 9'b000001000,
		ST_RELAX  = 9'b000010000,
		ST_WALK_W = 9'b000100000,
		ST_WALK_R = 9'b001000000,
		ST_EMIT_R = 9'b010000000,
		ST_EMIT_O = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

FILE: design/shortest_path_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_path_engine_top: single-pair shortest path search over a stored graph
// Adjacency memory plus per-vertex memory, searched by one sequencer that
// scans the frontier and relaxes the neighbors of each extracted vertex.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// item      in         start && !busy                mode, from_vertex, to_vertex, weight
// result    out        result_valid (one cycle)      path_vertex, path_distance, found, last
//
// An edge write is stored while the block stays idle. A clear, and the pass
// after reset, sweep the whole edge memory one entry a cycle. A query scans
// the frontier through the single read port of the vertex memory before each
// extracted vertex and relaxes that vertex's neighbors, then walks the path
// back and emits one result per path vertex.
// Results cannot be stalled; busy stays high until the last result is sent.
// ----------------------------------------------------------------------------
module shortest_path_engine_top
	import spe_pkg::*;
#(
	parameter int NUM_VERTICES = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             mode,
	input  wire logic [VERTEX_W-1:0]    from_vertex,
	input  wire logic [VERTEX_W-1:0]    to_vertex,
	input  wire logic [WEIGHT_IN_W-1:0] weight,
	output logic                        result_valid,
	output logic [VERTEX_W-1:0]         path_vertex,
	output logic [DIST_W-1:0]           path_distance,
	output logic                        found,
	output logic                        last
);

	localparam int VB = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int VDEPTH = 1 << VB;
	localparam int EDEPTH = VDEPTH * VDEPTH;
	localparam int SEQ_W = VB + 1;
	localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
	localparam logic [VB:0] N_CNT = (VB + 1)'(NUM_VERTICES);
	localparam logic [VB-1:0] N_LAST = VB'(NUM_VERTICES - 1);

	typedef struct packed {
		logic [DIST_W-1:0] cost;
		logic [VB-1:0]     pred;
		logic [SEQ_W-1:0]  seq;
	} node_t;

	state_t state_q;

	logic [WEIGHT_BITS:0] e_mem [EDEPTH];
	logic [WEIGHT_BITS:0] e_rd_s1;
	node_t                n_mem [VDEPTH];
	node_t                n_rd_s1;
	logic [VB-1:0]        p_mem [VDEPTH];
	logic [VB-1:0]        p_rd_s1;

	logic [2*VB-1:0] clr_q;
	logic [VB:0]     cnt_q;
	logic            vld_s1;
	logic [VB-1:0]   v_s1;
	logic [NUM_VERTICES-1:0] reached_q;
	logic [NUM_VERTICES-1:0] inf_q;
	logic [SEQ_W-1:0] seqcnt_q;
	logic [VB-1:0]   src_q, dst_q, u_q, cur_q, n_q, k_q;
	logic [DIST_W-1:0] du_q;
	logic            best_valid_q;
	logic [VB-1:0]   best_v_q;
	logic [DIST_W-1:0] best_d_q;
	logic [SEQ_W-1:0] best_seq_q;

	logic accept, from_ok, to_ok, issuing;
	logic e_we;
	logic [2*VB-1:0] e_wa, e_ra;
	logic [WEIGHT_BITS:0] e_wd;
	logic n_we;
	logic [VB-1:0] n_wa, n_ra;
	node_t n_wd;
	logic [SUM_W-1:0] sum;
	logic [DIST_W-1:0] nd;
	logic take, better;
	logic [NUM_VERTICES-1:0] src_hot;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign from_ok = {1'b0, from_vertex} < (VERTEX_W + 1)'(NUM_VERTICES);
	assign to_ok = {1'b0, to_vertex} < (VERTEX_W + 1)'(NUM_VERTICES);
	assign issuing = (cnt_q != N_CNT);
	assign src_hot = NUM_VERTICES'(1) << from_vertex[VB-1:0];

	// Relaxation of the neighbor whose data arrived this cycle.
	assign sum = SUM_W'(du_q) + SUM_W'(e_rd_s1[WEIGHT_BITS-1:0]);
	assign nd = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
	assign take = (state_q == ST_RELAX) && vld_s1 && e_rd_s1[WEIGHT_BITS]
		&& (!reached_q[v_s1] || nd < n_rd_s1.cost);

	// Frontier order: smaller distance first, then earlier insertion.
	assign better = (state_q == ST_SCAN) && vld_s1 && inf_q[v_s1]
		&& (!best_valid_q || n_rd_s1.cost < best_d_q
			|| (n_rd_s1.cost == best_d_q && n_rd_s1.seq < best_seq_q));

	always_comb begin
		e_we = 1'b0;
		e_wa = clr_q;
		e_wd = '0;
		if (state_q == ST_CLEAR) begin
			e_we = 1'b1;
		end else if (accept && mode == MODE_WRITE && from_ok && to_ok) begin
			e_we = 1'b1;
			e_wa = {from_vertex[VB-1:0], to_vertex[VB-1:0]};
			e_wd = {1'b1, WEIGHT_BITS'(weight)};
		end
	end

	assign e_ra = {u_q, cnt_q[VB-1:0]};
	assign n_ra = (state_q == ST_WALK_W) ? cur_q : cnt_q[VB-1:0];

	always_comb begin
		n_we = 1'b0;
		n_wa = v_s1;
		n_wd = '{cost: nd, pred: u_q, seq: (inf_q[v_s1] ? n_rd_s1.seq : seqcnt_q)};
		if (take) begin
			n_we = 1'b1;
		end else if (accept && mode == MODE_QUERY && from_ok && to_ok) begin
			n_we = 1'b1;
			n_wa = from_vertex[VB-1:0];
			n_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			e_mem[e_wa] <= e_wd;
		end
		e_rd_s1 <= e_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (n_we) begin
			n_mem[n_wa] <= n_wd;
		end
		n_rd_s1 <= n_mem[n_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK_W) begin
			p_mem[n_q] <= cur_q;
		end
		p_rd_s1 <= p_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			v_s1 <= '0;
			reached_q <= '0;
			inf_q <= '0;
			seqcnt_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			u_q <= '0;
			cur_q <= '0;
			n_q <= '0;
			k_q <= '0;
			du_q <= '0;
			best_valid_q <= 1'b0;
			best_v_q <= '0;
			best_d_q <= '0;
			best_seq_q <= '0;
			result_valid <= 1'b0;
			path_vertex <= '0;
			path_distance <= '0;
			found <= 1'b0;
			last <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			vld_s1 <= 1'b0;
			v_s1 <= cnt_q[VB-1:0];
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && mode == MODE_CLEAR) begin
						clr_q <= '0;
						state_q <= ST_CLEAR;
					end else if (accept && mode == MODE_QUERY) begin
						if (from_ok && to_ok) begin
							src_q <= from_vertex[VB-1:0];
							dst_q <= to_vertex[VB-1:0];
							reached_q <= src_hot;
							inf_q <= src_hot;
							seqcnt_q <= SEQ_W'(1);
							cnt_q <= '0;
							best_valid_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							result_valid <= 1'b1;
							path_vertex <= '0;
							path_distance <= '0;
							found <= 1'b0;
							last <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (better) begin
						best_valid_q <= 1'b1;
						best_v_q <= v_s1;
						best_d_q <= n_rd_s1.cost;
						best_seq_q <= n_rd_s1.seq;
					end
					if (issuing) begin
						vld_s1 <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!best_valid_q) begin
						result_valid <= 1'b1;
						path_vertex <= '0;
						path_distance <= '0;
						found <= 1'b0;
						last <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						u_q <= best_v_q;
						du_q <= best_d_q;
						inf_q[best_v_q] <= 1'b0;
						cnt_q <= '0;
						if (best_v_q == dst_q) begin
							cur_q <= dst_q;
							n_q <= '0;
							state_q <= ST_WALK_W;
						end else begin
							state_q <= ST_RELAX;
						end
					end
				end
				ST_RELAX: begin
					if (take) begin
						reached_q[v_s1] <= 1'b1;
						if (!inf_q[v_s1]) begin
							inf_q[v_s1] <= 1'b1;
							seqcnt_q <= seqcnt_q + 1'b1;
						end
					end
					if (issuing) begin
						vld_s1 <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
						best_valid_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_WALK_W: begin
					if (cur_q == src_q || n_q == N_LAST) begin
						k_q <= n_q;
						state_q <= ST_EMIT_R;
					end else begin
						n_q <= n_q + 1'b1;
						state_q <= ST_WALK_R;
					end
				end
				ST_WALK_R: begin
					cur_q <= n_rd_s1.pred;
					state_q <= ST_WALK_W;
				end
				ST_EMIT_R: begin
					state_q <= ST_EMIT_O;
				end
				ST_EMIT_O: begin
					result_valid <= 1'b1;
					path_vertex <= VERTEX_W'(p_rd_s1);
					path_distance <= du_q;
					found <= 1'b1;
					last <= (k_q == '0);
					if (k_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q - 1'b1;
						state_q <= ST_EMIT_R;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/spe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_checker: port-level checks of the shortest path engine
// Watches the item and result channels over time.
// ----------------------------------------------------------------------------
module spe_checker
	import spe_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [1:0]        mode,
	input wire logic              result_valid,
	input wire logic [DIST_W-1:0] path_distance,
	input wire logic              found,
	input wire logic              last
);

	// A not-found result is always the only transfer of its query.
	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> last && path_distance == '0)
		else $error("not-found result without last or with a distance");

	// Edge writes and unused codes finish at once and give no result.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == MODE_WRITE || mode == MODE_NONE) |=> !busy && !result_valid)
		else $error("edge write or unused code caused activity");

	// More results follow a non-final one, so the block stays busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> busy)
		else $error("idle before the final result of a path");

	// A non-final path result is never followed back to back by another result.
	a_path_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> !result_valid)
		else $error("back-to-back path results");

endmodule

bind shortest_path_engine_top spe_checker u_spe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.result_valid (result_valid),
	.path_distance(path_distance),
	.found        (found),
	.last         (last)
);

`default_nettype wire
